### hdl/tlbpat_pkg.sv
`default_nettype none

package tlbpat_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_COUNT  = 256;
    localparam int FRAME_COUNT = 256;
    localparam int PAGE_BYTES  = 256;

    localparam int ADDR_W    = 16;
    localparam int FRAME_W   = 8;
    localparam int CNT_W     = 32;
    localparam int OFFSET_W  = $clog2(PAGE_BYTES);
    localparam int PAGE_W    = $clog2(PAGE_COUNT);
    localparam int TLB_IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int NFF_W     = $clog2(FRAME_COUNT + 1);

    localparam int S_TDATA_W = 16;
    localparam int M_FIELDS_W = ADDR_W + FRAME_W + 3 + 2 * CNT_W;
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELDS_W;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } tlb_lookup_t;

    typedef struct packed {
        logic               en;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } tlb_refill_t;

endpackage

`default_nettype wire

### hdl/tlbpat_tlb.sv
`default_nettype none

module tlbpat_tlb (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [tlbpat_pkg::PAGE_W-1:0]   lookup_page,
    input  tlbpat_pkg::tlb_refill_t         refill,
    output tlbpat_pkg::tlb_lookup_t         result
);
    import tlbpat_pkg::*;

    logic [PAGE_W-1:0]      tag_reg   [TLB_ENTRIES];
    logic [FRAME_W-1:0]     frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] valid_reg;
    logic [TLB_IDX_W-1:0]   ptr_reg;
    logic [TLB_IDX_W-1:0]   ptr_next;

    // scan downward so the lowest matching entry wins
    always_comb begin
        result = '0;
        for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
            if (valid_reg[k] && tag_reg[k] == lookup_page) begin
                result.hit   = 1'b1;
                result.frame = frame_reg[k];
            end
        end
    end

    always_comb begin
        if (ptr_reg == TLB_IDX_W'(TLB_ENTRIES - 1)) begin
            ptr_next = '0;
        end else begin
            ptr_next = ptr_reg + TLB_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            ptr_reg   <= '0;
        end else if (refill.en) begin
            valid_reg[ptr_reg] <= 1'b1;
            ptr_reg            <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (refill.en) begin
            tag_reg[ptr_reg]   <= refill.page;
            frame_reg[ptr_reg] <= refill.frame;
        end
    end

endmodule

`default_nettype wire

### hdl/tlb_paged_address_translator_core.sv
`default_nettype none

// Paged address translator with a fully associative TLB and demand paging.
// Input channel s_*: one 16-bit logical address per transaction; the upper
// bits select the page, the lower bits are the offset within the page.
// Output channel m_*: one result transaction per input transaction, in order,
// carrying the physical address, frame, hit/fault/out-of-frames flags and
// the running hit and fault counts.
// Each transaction passes through IDLE, which accepts it and issues the page
// table read, then LOOKUP, which compares the TLB, sees the read data, allocates
// a frame on a fault and refills the TLB entry at the FIFO pointer. The page
// table read is registered. LOOKUP waits while the output register is full and
// not taken; no new address is accepted until the block is back in IDLE.
// A finished result sits in an output register; the next address is accepted
// while it waits. If the receiver still stalls when the following result is
// ready, the block holds that transaction and accepts nothing more.
// Reset (aresetn low, synchronous) clears TLB valid bits, page mapped bits,
// the FIFO pointer, the free frame counter and both counters; no sweep.

module tlb_paged_address_translator_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] logical_address
    input  logic [tlbpat_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [15:0] physical_address, [23:16] frame_number, [24] tlb_hit,
    // [25] page_fault, [26] out_of_frames, [58:27] hits_so_far,
    // [90:59] faults_so_far, upper bits zero
    output logic [tlbpat_pkg::M_TDATA_W-1:0]   m_tdata
);
    import tlbpat_pkg::*;

    typedef enum logic {IDLE, LOOKUP} state_t;

    state_t                 state_reg;
    logic [PAGE_W-1:0]      page_reg;
    logic [OFFSET_W-1:0]    offset_reg;
    logic [FRAME_W-1:0]     pt_rdata_reg;
    logic [PAGE_COUNT-1:0]  mapped_reg;
    logic [NFF_W-1:0]       free_reg;
    logic [CNT_W-1:0]       hits_reg;
    logic [CNT_W-1:0]       faults_reg;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;

    logic [FRAME_W-1:0]     pt_mem [PAGE_COUNT];

    logic                   s_accept;
    logic [PAGE_W-1:0]      s_page;
    logic                   go;
    logic                   mapped;
    logic                   have_free;
    logic                   miss;
    logic                   alloc;
    logic                   oof;
    logic [FRAME_W-1:0]     frame_sel;
    logic [ADDR_W-1:0]      phys;
    logic [CNT_W-1:0]       hits_next;
    logic [CNT_W-1:0]       faults_next;
    logic [M_TDATA_W-1:0]   m_tdata_next;

    tlb_lookup_t            tlb_res;
    tlb_refill_t            tlb_fill;

    assign s_tready = (state_reg == IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign s_page   = s_tdata[OFFSET_W +: PAGE_W];

    // resolve only when the output register can take the result
    assign go        = (state_reg == LOOKUP) && (!m_tvalid_reg || m_tready);
    assign mapped    = mapped_reg[page_reg];
    assign have_free = (free_reg < NFF_W'(FRAME_COUNT));
    assign miss      = !tlb_res.hit;
    assign alloc     = miss && !mapped && have_free;
    assign oof       = miss && !mapped && !have_free;

    always_comb begin
        if (tlb_res.hit) begin
            frame_sel = tlb_res.frame;
        end else if (mapped) begin
            frame_sel = pt_rdata_reg;
        end else if (have_free) begin
            frame_sel = FRAME_W'(free_reg);
        end else begin
            frame_sel = '0;
        end
    end

    assign phys = oof ? '0 : ADDR_W'({frame_sel, offset_reg});

    assign hits_next   = hits_reg + CNT_W'(tlb_res.hit);
    assign faults_next = faults_reg + CNT_W'(alloc);

    assign m_tdata_next = {{M_PAD_W{1'b0}}, faults_next, hits_next, oof, alloc,
                           tlb_res.hit, frame_sel, phys};

    assign tlb_fill.en    = go && miss && !oof;
    assign tlb_fill.page  = page_reg;
    assign tlb_fill.frame = frame_sel;

    tlbpat_tlb u_tlb (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .lookup_page (page_reg),
        .refill      (tlb_fill),
        .result      (tlb_res)
    );

    // page table memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (go && alloc) begin
            pt_mem[page_reg] <= frame_sel;
        end
        if (s_accept) begin
            pt_rdata_reg <= pt_mem[s_page];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            mapped_reg   <= '0;
            free_reg     <= '0;
            hits_reg     <= '0;
            faults_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                IDLE: begin
                    if (s_accept) begin
                        state_reg <= LOOKUP;
                    end
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                end
                LOOKUP: begin
                    if (go) begin
                        state_reg    <= IDLE;
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= m_tdata_next;
                        hits_reg     <= hits_next;
                        faults_reg   <= faults_next;
                        if (alloc) begin
                            mapped_reg[page_reg] <= 1'b1;
                            free_reg             <= free_reg + NFF_W'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            page_reg   <= s_page;
            offset_reg <= s_tdata[OFFSET_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
